// ----- sv/dltq_pkg.sv -----
`timescale 1ns / 1ps

package dltq_pkg;

  // Number of timer slots and the widths that follow from it.
  localparam int unsigned SLOTS   = 32;
  localparam int unsigned ID_W    = 5;          // slot index width
  localparam int unsigned PTR_W   = ID_W + 1;   // link width, top bit marks null
  localparam int unsigned DELTA_W = 32;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [DELTA_W-1:0] delta_t;

  // Null link: SLOTS, i.e. only the top bit set.
  localparam ptr_t NULL_PTR = ptr_t'(SLOTS);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_QUEUED     = 2'd1,
    STAT_NOT_QUEUED = 2'd2
  } status_e;

  // One slot record: successor link and delta to the slot ahead.
  typedef struct packed {
    ptr_t   next;
    delta_t delta;
  } entry_t;

endpackage

// ----- sv/delta_list_timer_queue.sv -----
`timescale 1ns / 1ps

// Delta-list timer queue over 32 timer slots. Each request (insert, remove,
// query) is one slave-side stream transaction and yields exactly one
// master-side result transaction. The queued slots form one chain; each slot
// record holds only the ticks left after the slot ahead of it. Slot records
// live in a 32-entry single-port-read memory with a registered read, so the
// chain is walked one slot per cycle; a single 32-bit add/subtract unit does
// every delta update, compare and running sum. A query or a remove walks the
// chain up to the named slot; a remove also rewrites the successor record
// when the slot has a successor; an insert walks to its place and also cuts
// the delta of the slot behind the new one when it splits a slot. An insert
// into an empty chain skips the walk. After each result the sequencer returns
// to idle before the next accept. The
// block takes one request at a time: s_axis_tready is high only
// while the sequencer is idle. A finished result sits in an output register,
// so the walk of the next request is not held up by the master side until
// that next result is ready to be loaded. Equal deadlines keep FIFO order.
// Errors: inserting a queued slot gives status 1, removing or querying an
// unqueued slot gives status 2 with zero ticks; request kind 3 gives status 0
// and zero ticks and changes nothing.
module delta_list_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [4:0] slot_id, [36:5] delay_ticks, [39:37] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] remaining_ticks
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned ID_W    = dltq_pkg::ID_W;
  localparam int unsigned DELTA_W = dltq_pkg::DELTA_W;
  localparam int unsigned SLOTS   = dltq_pkg::SLOTS;

  typedef enum logic [2:0] {
    ST_IDLE,      // waiting for a request
    ST_WALK,      // rd_q holds the record of cur_q
    ST_SPLIT,     // insert: cut the delta of the slot behind the new one
    ST_NXT,       // remove: rd_q holds the successor record
    ST_LINK_ID,   // insert: write the new slot record
    ST_LINK_PREV, // patch predecessor link or head, update queued flag
    ST_RESP       // move result into the output register
  } state_e;

  state_e                state_q, state_d;
  dltq_pkg::req_e        req_q, req_d;
  logic [ID_W-1:0]       id_q, id_d;
  dltq_pkg::delta_t      delay_q, delay_d;       // insert: delay left; remove: removed delta
  dltq_pkg::ptr_t        cur_q, cur_d;
  dltq_pkg::ptr_t        prev_q, prev_d;
  dltq_pkg::delta_t      prev_delta_q, prev_delta_d;
  dltq_pkg::delta_t      sum_q, sum_d;           // query sum, then result ticks
  dltq_pkg::status_e     res_status_q, res_status_d;
  dltq_pkg::ptr_t        head_q, head_d;
  logic [SLOTS-1:0]      queued_q, queued_d;
  logic                  m_valid_q, m_valid_d;
  dltq_pkg::delta_t      m_rem_q, m_rem_d;
  dltq_pkg::status_e     m_status_q, m_status_d;

  // Slot record memory
  dltq_pkg::entry_t      mem_q [SLOTS];
  dltq_pkg::entry_t      rd_q;
  logic [ID_W-1:0]       rd_addr;
  logic                  wr_en;
  logic [ID_W-1:0]       wr_addr;
  dltq_pkg::entry_t      wr_data;

  // Shared add/subtract unit; carry out on subtract means a >= b
  dltq_pkg::delta_t      alu_a, alu_b;
  logic                  alu_sub;
  logic [DELTA_W:0]      alu_sum;
  dltq_pkg::delta_t      alu_res;
  logic                  alu_ge;

  logic                  s_fire;
  logic                  out_free;
  logic [ID_W-1:0]       s_id;
  dltq_pkg::ptr_t        link_tgt;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_id          = s_axis_tdata[ID_W-1:0];
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_rem_q;
  assign m_axis_tuser  = m_status_q;

  always_comb begin
    alu_a   = sum_q;
    alu_b   = rd_q.delta;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_WALK: begin
        if (req_q == dltq_pkg::REQ_INSERT) begin
          alu_a   = delay_q;
          alu_sub = 1'b1;
        end
      end
      ST_SPLIT: begin
        alu_a   = rd_q.delta;
        alu_b   = delay_q;
        alu_sub = 1'b1;
      end
      ST_NXT: begin
        alu_a = rd_q.delta;
        alu_b = delay_q;
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {DELTA_W{alu_sub}}}
                 + (DELTA_W+1)'(alu_sub);
  assign alu_res = alu_sum[DELTA_W-1:0];
  assign alu_ge  = alu_sum[DELTA_W];

  // Link written into the predecessor (or head) at the end of a request
  assign link_tgt = (req_q == dltq_pkg::REQ_INSERT) ? dltq_pkg::ptr_t'(id_q) : cur_q;

  // Read address follows the next cursor so rd_q always holds cur_q's record
  assign rd_addr = cur_d[ID_W-1:0];

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    id_d         = id_q;
    delay_d      = delay_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_delta_d = prev_delta_q;
    sum_d        = sum_q;
    res_status_d = res_status_q;
    head_d       = head_q;
    queued_d     = queued_q;
    m_valid_d    = m_valid_q;
    m_rem_d      = m_rem_q;
    m_status_d   = m_status_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q[ID_W-1:0];
    wr_data      = rd_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          req_d        = dltq_pkg::req_e'(s_axis_tuser);
          id_d         = s_id;
          delay_d      = s_axis_tdata[ID_W +: DELTA_W];
          cur_d        = head_q;
          prev_d       = dltq_pkg::NULL_PTR;
          sum_d        = '0;
          res_status_d = dltq_pkg::STAT_OK;
          unique case (s_axis_tuser)
            dltq_pkg::REQ_INSERT: begin
              if (queued_q[s_id]) begin
                res_status_d = dltq_pkg::STAT_QUEUED;
                state_d      = ST_RESP;
              end else if (head_q == dltq_pkg::NULL_PTR) begin
                state_d = ST_LINK_ID;
              end else begin
                state_d = ST_WALK;
              end
            end
            dltq_pkg::REQ_REMOVE, dltq_pkg::REQ_QUERY: begin
              if (!queued_q[s_id]) begin
                res_status_d = dltq_pkg::STAT_NOT_QUEUED;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_WALK: begin
        unique case (req_q)
          dltq_pkg::REQ_INSERT: begin
            if (alu_ge) begin
              // pass this slot: new deadline is not earlier
              delay_d      = alu_res;
              prev_d       = cur_q;
              prev_delta_d = rd_q.delta;
              cur_d        = rd_q.next;
              if (rd_q.next == dltq_pkg::NULL_PTR) begin
                state_d = ST_LINK_ID;
              end
            end else begin
              state_d = ST_SPLIT;
            end
          end
          dltq_pkg::REQ_REMOVE: begin
            if (cur_q[ID_W-1:0] == id_q) begin
              delay_d = rd_q.delta;
              cur_d   = rd_q.next;
              if (rd_q.next == dltq_pkg::NULL_PTR) begin
                state_d = ST_LINK_PREV;
              end else begin
                state_d = ST_NXT;
              end
            end else begin
              prev_d       = cur_q;
              prev_delta_d = rd_q.delta;
              cur_d        = rd_q.next;
            end
          end
          default: begin
            // query: running sum up to the named slot
            sum_d = alu_res;
            if (cur_q[ID_W-1:0] == id_q) begin
              state_d = ST_RESP;
            end else if (rd_q.next == dltq_pkg::NULL_PTR) begin
              sum_d   = '0;
              state_d = ST_RESP;
            end else begin
              cur_d = rd_q.next;
            end
          end
        endcase
      end

      ST_SPLIT: begin
        wr_en         = 1'b1;
        wr_data.next  = rd_q.next;
        wr_data.delta = alu_res;
        state_d       = ST_LINK_ID;
      end

      ST_NXT: begin
        // successor absorbs the removed delta
        wr_en         = 1'b1;
        wr_data.next  = rd_q.next;
        wr_data.delta = alu_res;
        state_d       = ST_LINK_PREV;
      end

      ST_LINK_ID: begin
        wr_en         = 1'b1;
        wr_addr       = id_q;
        wr_data.next  = cur_q;
        wr_data.delta = delay_q;
        state_d       = ST_LINK_PREV;
      end

      ST_LINK_PREV: begin
        if (prev_q == dltq_pkg::NULL_PTR) begin
          head_d = link_tgt;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = prev_q[ID_W-1:0];
          wr_data.next  = link_tgt;
          wr_data.delta = prev_delta_q;
        end
        queued_d[id_q] = (req_q == dltq_pkg::REQ_INSERT);
        sum_d          = '0;
        state_d        = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_rem_d    = sum_q;
          m_status_d = res_status_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= dltq_pkg::NULL_PTR;
      queued_q     <= '0;
      m_valid_q    <= 1'b0;
      req_q        <= dltq_pkg::REQ_INSERT;
      res_status_q <= dltq_pkg::STAT_OK;
      m_status_q   <= dltq_pkg::STAT_OK;
      cur_q        <= dltq_pkg::NULL_PTR;
      prev_q       <= dltq_pkg::NULL_PTR;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      queued_q     <= queued_d;
      m_valid_q    <= m_valid_d;
      req_q        <= req_d;
      res_status_q <= res_status_d;
      m_status_q   <= m_status_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    delay_q      <= delay_d;
    prev_delta_q <= prev_delta_d;
    sum_q        <= sum_d;
    m_rem_q      <= m_rem_d;
  end

  // Slot record memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // An empty chain means no slot is marked queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == dltq_pkg::NULL_PTR) |-> (queued_q == '0))
    else $error("chain empty while slots are marked queued");

  // A nonzero tick count only comes with a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != dltq_pkg::STAT_OK)) |-> (m_axis_tdata == '0))
    else $error("error result carries nonzero ticks");

  // The walk only visits real slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cur_q != dltq_pkg::NULL_PTR))
    else $error("chain walk on a null link");

  // A request accepted now is not answered in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("sequencer back to idle without producing a result");

endmodule
